// File: design/bpu_pkg.sv
// Shared types, constants and helpers for the byte-plane unshuffle block.
`default_nettype none
package bpu_pkg;

   localparam int ELEMENTS_MAX_DEF = 4096;
   localparam int WIDTH_MAX_DEF    = 8;

   localparam int BYTE_W        = 8;
   localparam int PLANE_W       = 3;
   localparam int VALUE_BYTES   = 8;
   localparam int VALUE_W       = 64;
   localparam int INDEX_W       = 12;
   localparam int WIDTH_CFG_W   = 4;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 13;
   localparam int RSP_DATA_W    = 80;

   localparam int RESET_WIDTH   = 4;
   localparam int RESET_COUNT   = 4096;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = 2;
   localparam int QUEUE_LEVEL_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ELEMENT_WIDTH = 4'd0,
      CSR_ELEMENT_COUNT = 4'd1
   } csr_index_type;

   // One element headed for the result queue.
   typedef struct packed {
      logic                block_last;
      logic [INDEX_W-1:0]  element_index;
      logic [VALUE_W-1:0]  element_value;
   } result_type;

   // Final-plane byte waiting for its stored lower planes.
   typedef struct packed {
      logic [BYTE_W-1:0]   data_byte;
      logic [PLANE_W-1:0]  final_plane;
      logic [INDEX_W-1:0]  element_index;
      logic                block_last;
   } slot_type;

   // Last plane index for a written width: zero reads as one, large values saturate.
   function automatic logic [PLANE_W-1:0] final_plane_of(logic [WIDTH_CFG_W-1:0] width,
                                                          int width_max);
      int w;
      w = int'(width);
      if (w == 0) w = 1;
      if (w > width_max) w = width_max;
      return PLANE_W'(w - 1);
   endfunction

   // Last element index for a written count: zero reads as one, large values saturate.
   function automatic int last_index_of(logic [CSR_DATA_W-1:0] count, int elements_max);
      int n;
      n = int'(count);
      if (n == 0) n = 1;
      if (n > elements_max) n = elements_max;
      return n - 1;
   endfunction

endpackage
`default_nettype wire

// File: design/bpu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: design/bpu_front.sv
// Front end: config registers, plane/index counters, per-plane byte stores.
`default_nettype none
module bpu_front #(
   parameter int ELEMENTS_MAX = bpu_pkg::ELEMENTS_MAX_DEF,
   parameter int WIDTH_MAX    = bpu_pkg::WIDTH_MAX_DEF,
   localparam int LANES      = WIDTH_MAX - 1,
   localparam int LANE_SLOTS = (WIDTH_MAX > 1) ? WIDTH_MAX - 1 : 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [bpu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bpu_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire logic                                take,
   input  wire logic [bpu_pkg::BYTE_W-1:0]          data_byte,
   output logic                                     slot_valid,
   output bpu_pkg::slot_type                        slot,
   output logic [LANE_SLOTS-1:0][bpu_pkg::BYTE_W-1:0] stored_bytes
);

   localparam int IDX_W = (ELEMENTS_MAX > 1) ? $clog2(ELEMENTS_MAX) : 1;

   logic [bpu_pkg::PLANE_W-1:0] fin_ff, fin_in;
   logic [IDX_W-1:0]            last_ff, last_in;
   logic [bpu_pkg::PLANE_W-1:0] plane_ff, plane_in;
   logic [IDX_W-1:0]            index_ff, index_in;
   logic                        slot_valid_ff, slot_valid_in;
   bpu_pkg::slot_type           slot_ff, slot_in;

   logic is_final;
   logic idx_end;

   assign is_final = (plane_ff >= fin_ff);
   assign idx_end  = (index_ff >= last_ff);

   always_comb begin
      fin_in  = fin_ff;
      last_in = last_ff;
      if (csr_valid) begin
         unique case (bpu_pkg::csr_index_type'(csr_index))
            bpu_pkg::CSR_ELEMENT_WIDTH: begin
               fin_in = bpu_pkg::final_plane_of(csr_data[bpu_pkg::WIDTH_CFG_W-1:0], WIDTH_MAX);
            end
            bpu_pkg::CSR_ELEMENT_COUNT: begin
               last_in = IDX_W'(bpu_pkg::last_index_of(csr_data, ELEMENTS_MAX));
            end
            default: begin
            end
         endcase
      end
   end

   // Advance index per beat; wrap at block end and step the plane unless it was the last.
   always_comb begin
      plane_in = plane_ff;
      index_in = index_ff;
      if (take) begin
         if (idx_end) begin
            index_in = '0;
            plane_in = is_final ? '0 : plane_ff + 1'b1;
         end else begin
            index_in = index_ff + 1'b1;
         end
      end
   end

   assign slot_valid_in = take && is_final;

   always_comb begin
      slot_in.data_byte     = data_byte;
      slot_in.final_plane   = fin_ff;
      slot_in.element_index = bpu_pkg::INDEX_W'(index_ff);
      slot_in.block_last    = idx_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff        <= bpu_pkg::final_plane_of(bpu_pkg::WIDTH_CFG_W'(bpu_pkg::RESET_WIDTH),
                                                  WIDTH_MAX);
         last_ff       <= IDX_W'(bpu_pkg::last_index_of(
                                   bpu_pkg::CSR_DATA_W'(bpu_pkg::RESET_COUNT), ELEMENTS_MAX));
         plane_ff      <= '0;
         index_ff      <= '0;
         slot_valid_ff <= 1'b0;
      end else begin
         fin_ff        <= fin_in;
         last_ff       <= last_in;
         plane_ff      <= plane_in;
         index_ff      <= index_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_valid_in) begin
         slot_ff <= slot_in;
      end
   end

   assign slot_valid = slot_valid_ff;
   assign slot       = slot_ff;

   // One byte-wide store per non-final plane. Plane zero rewrites every lane,
   // zeroing the upper ones; later planes touch only their own lane.
   generate
      if (LANES > 0) begin : g_lanes
         for (genvar k = 0; k < LANES; k++) begin : g_lane
            logic                        lane_we;
            logic [bpu_pkg::BYTE_W-1:0]  lane_wdata;

            assign lane_we    = take && !is_final &&
                                ((plane_ff == '0) || (plane_ff == bpu_pkg::PLANE_W'(k)));
            assign lane_wdata = (plane_ff == bpu_pkg::PLANE_W'(k)) ? data_byte : '0;

            bpu_ram #(
               .WIDTH (bpu_pkg::BYTE_W),
               .DEPTH (ELEMENTS_MAX)
            ) u_lane_ram (
               .clock   (clock),
               .wr_en   (lane_we),
               .wr_addr (index_ff),
               .wr_data (lane_wdata),
               .rd_en   (slot_valid_in),
               .rd_addr (index_ff),
               .rd_data (stored_bytes[k])
            );
         end
      end else begin : g_no_lanes
         assign stored_bytes = '0;
      end
   endgenerate

endmodule
`default_nettype wire

// File: design/bpu_queue.sv
// Result queue between element assembly and the rsp channel.
`default_nettype none
module bpu_queue (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   input  wire bpu_pkg::result_type               push_data,
   input  wire logic                              pop,
   output logic                                   head_valid,
   output bpu_pkg::result_type                    head_data,
   output logic [bpu_pkg::QUEUE_LEVEL_W-1:0]      level
);

   bpu_pkg::result_type                 entry_ff [bpu_pkg::QUEUE_DEPTH];
   logic [bpu_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bpu_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bpu_pkg::QUEUE_LEVEL_W-1:0]   count_ff, count_in;
   logic                                do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign level      = count_ff;

endmodule
`default_nettype wire

// File: design/byte_plane_unshuffle_top.sv
// Path: a final-plane req beat goes to the slot register, then the result queue.
// Throughput: one byte per cycle unless stalled; the lane stores write one plane byte
//   or read the lower planes once per beat, and only final-plane bytes give a rsp beat.
// Reset: counters cleared, width 4 and count 4096 restored, result queue emptied;
//   stored bytes are not cleared and need no clearing pass.
`default_nettype none
module byte_plane_unshuffle_top #(
   parameter int ELEMENTS_MAX = bpu_pkg::ELEMENTS_MAX_DEF,
   parameter int WIDTH_MAX    = bpu_pkg::WIDTH_MAX_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bpu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bpu_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [bpu_pkg::BYTE_W-1:0]         req_tdata,   // [7:0] data_byte
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [bpu_pkg::RSP_DATA_W-1:0]          rsp_tdata,   // [63:0] element_value,
                                                                // [75:64] element_index
   output logic                                    rsp_tlast
);

   localparam int LANES      = WIDTH_MAX - 1;
   localparam int LANE_SLOTS = (WIDTH_MAX > 1) ? WIDTH_MAX - 1 : 1;

   logic                                        take;
   logic                                        slot_valid;
   bpu_pkg::slot_type                           slot;
   logic [LANE_SLOTS-1:0][bpu_pkg::BYTE_W-1:0]  stored_bytes;
   logic [bpu_pkg::VALUE_BYTES-1:0][bpu_pkg::BYTE_W-1:0] value_bytes;
   bpu_pkg::result_type                         result;
   bpu_pkg::result_type                         head;
   logic [bpu_pkg::QUEUE_LEVEL_W-1:0]           level;

   assign csr_ready = 1'b1;

   // Hold off input unless the queue can absorb the element already in flight too.
   assign req_tready = (({1'b0, level} + {{bpu_pkg::QUEUE_LEVEL_W{1'b0}}, slot_valid})
                        < (bpu_pkg::QUEUE_LEVEL_W + 1)'(bpu_pkg::QUEUE_DEPTH));
   assign take       = req_tvalid && req_tready;

   bpu_front #(
      .ELEMENTS_MAX (ELEMENTS_MAX),
      .WIDTH_MAX    (WIDTH_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .take         (take),
      .data_byte    (req_tdata),
      .slot_valid   (slot_valid),
      .slot         (slot),
      .stored_bytes (stored_bytes)
   );

   // Lower planes from the stores, final plane from the beat, zero above.
   generate
      for (genvar k = 0; k < bpu_pkg::VALUE_BYTES; k++) begin : g_byte
         if (k < LANES) begin : g_stored
            assign value_bytes[k] =
               (bpu_pkg::PLANE_W'(k) < slot.final_plane)  ? stored_bytes[k] :
               (bpu_pkg::PLANE_W'(k) == slot.final_plane) ? slot.data_byte  : '0;
         end else begin : g_top
            assign value_bytes[k] =
               (bpu_pkg::PLANE_W'(k) == slot.final_plane) ? slot.data_byte : '0;
         end
      end
   endgenerate

   always_comb begin
      result.element_value = value_bytes;
      result.element_index = slot.element_index;
      result.block_last    = slot.block_last;
   end

   bpu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (slot_valid),
      .push_data  (result),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_data  (head),
      .level      (level)
   );

   assign rsp_tdata = {{(bpu_pkg::RSP_DATA_W - bpu_pkg::VALUE_W - bpu_pkg::INDEX_W){1'b0}},
                       head.element_index, head.element_value};
   assign rsp_tlast = head.block_last;

endmodule
`default_nettype wire

// File: tb/byte_plane_unshuffle_top_test.sv
// Self-checking stream testbench for the byte-plane unshuffle top level.
module byte_plane_unshuffle_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 200;
   localparam int HOLD_AFTER    = 8;
   localparam int HOLD_BYTES    = 48;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_BYTES  = 540;

   typedef struct packed {
      bit         last;
      bit [11:0]  index;
      bit [63:0]  value;
   } elem_type;

   typedef enum bit { ROW_BYTE, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type            kind;
      bpu_pkg::csr_index_type  sel;
      bit [12:0]               value;
      bit                      typed;
      elem_type                want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [12:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;         // [63:0] element_value, [75:64] element_index
   logic        rsp_tlast;

   byte_plane_unshuffle_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Predictor state
   bit [3:0]  cfg_width = 4'd4;
   bit [12:0] cfg_count = 13'd4096;
   int        plane_ctr = 0;
   int        idx_ctr = 0;
   bit [55:0] plane_store [4096];

   elem_type     pending_elements[$];
   dir_row_type  directed_rows[$];
   int           mismatch_count = 0;
   int           elements_seen = 0;
   int           bytes_sent = 0;
   int           burst_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int eff_planes();
      if (cfg_width == 0) return 1;
      if (cfg_width > 8) return 8;
      return int'(cfg_width);
   endfunction

   function automatic int eff_elements();
      if (cfg_count == 0) return 1;
      if (cfg_count > 4096) return 4096;
      return int'(cfg_count);
   endfunction

   // Advance the unshuffle state by one byte; return 1 when an element completes.
   function automatic bit unshuffle_step(input bit [7:0] b, output elem_type r);
      int        w;
      int        n;
      int        fin;
      int        slot;
      bit        idx_end;
      bit [63:0] keep;
      w = eff_planes();
      n = eff_elements();
      idx_end = (idx_ctr >= n - 1);
      slot = (idx_ctr < 4096) ? idx_ctr : 4095;
      r = '0;
      if (plane_ctr >= w - 1) begin
         fin = w - 1;
         keep = (fin == 0) ? 64'd0 : ((64'd1 << (8 * fin)) - 64'd1);
         r.value = ({8'h00, plane_store[slot]} & keep) | (64'(b) << (8 * fin));
         r.index = idx_ctr[11:0];
         r.last = idx_end;
         if (idx_end) begin
            idx_ctr = 0;
            plane_ctr = 0;
         end else begin
            idx_ctr = idx_ctr + 1;
         end
         return 1'b1;
      end
      if (plane_ctr == 0) begin
         plane_store[slot] = 56'(b);
      end else begin
         plane_store[slot][8 * plane_ctr +: 8] = b;
      end
      if (idx_end) begin
         idx_ctr = 0;
         plane_ctr = plane_ctr + 1;
      end else begin
         idx_ctr = idx_ctr + 1;
      end
      return 1'b0;
   endfunction

   task automatic send_byte(input bit [7:0] b, input bit typed, input elem_type want);
      int       gap;
      elem_type got;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent = bytes_sent + 1;
      if (unshuffle_step(b, got)) pending_elements.push_back(typed ? want : got);
   endtask

   // Hold the sender until every element is out and the pipeline has drained.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input bpu_pkg::csr_index_type sel, input bit [12:0] val);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (sel)
         bpu_pkg::CSR_ELEMENT_WIDTH: cfg_width = val[3:0];
         bpu_pkg::CSR_ELEMENT_COUNT: cfg_count = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic add_byte(input bit [7:0] b);
      dir_row_type row;
      row.kind = ROW_BYTE;
      row.sel = bpu_pkg::CSR_ELEMENT_WIDTH;
      row.value = 13'(b);
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_result(input bit [7:0] b, input bit [63:0] v, input bit [11:0] i,
                             input bit l);
      dir_row_type row;
      row.kind = ROW_BYTE;
      row.sel = bpu_pkg::CSR_ELEMENT_WIDTH;
      row.value = 13'(b);
      row.typed = 1'b1;
      row.want = '{last: l, index: i, value: v};
      directed_rows.push_back(row);
   endtask

   task automatic add_csr(input bpu_pkg::csr_index_type sel, input bit [12:0] val);
      dir_row_type row;
      row.kind = ROW_CSR;
      row.sel = sel;
      row.value = val;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endtask

   // Result checker
   always @(posedge clock) begin
      elem_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         elements_seen <= elements_seen + 1;
         if (pending_elements.size() == 0) begin
            $error("rsp beat with no element expected: data %0h last %0b", rsp_tdata, rsp_tlast);
            mismatch_count = mismatch_count + 1;
         end else begin
            want = pending_elements.pop_front();
            if (rsp_tdata[63:0] !== want.value) begin
               $error("element_value: expected %0h, got %0h", want.value, rsp_tdata[63:0]);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_tdata[75:64] !== want.index) begin
               $error("element_index: expected %0d, got %0d", want.index, rsp_tdata[75:64]);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_tlast !== want.last) begin
               $error("block_last: expected %0b, got %0b", want.last, rsp_tlast);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_tdata[79:76] !== 4'h0) begin
               $error("rsp_tdata padding: expected 0, got %0h", rsp_tdata[79:76]);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   // Receiver: segments of steady, random and sparse ready, plus one long hold.
   initial begin
      int seg_len;
      int mode;
      bit held;
      held = 1'b0;
      forever begin
         seg_len = $urandom_range(1, 40);
         mode = $urandom_range(0, 3);
         repeat (seg_len) begin
            if (!held && elements_seen >= HOLD_AFTER) begin
               held = 1'b1;
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end
            case (mode)
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= 1'b1;
            endcase
            @(posedge clock);
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet = quiet + 1;
      end
      $display("FAIL byte_plane_unshuffle_top");
      $finish;
   end

   initial begin
      int       blocks;
      int       cut;
      int       base;
      bit       trunc;
      elem_type none;
      none = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults (width 4, count 4096), then shrink the count mid-block
      add_byte(8'h00);
      add_byte(8'hFF);
      add_csr(bpu_pkg::CSR_ELEMENT_COUNT, 13'd1);
      add_byte(8'h5A);
      add_byte(8'h01);
      add_byte(8'h80);
      add_result(8'hFF, 64'hFF80_0100, 12'd0, 1'b1);
      // Width zero acts as pass-through
      add_csr(bpu_pkg::CSR_ELEMENT_WIDTH, 13'd0);
      add_csr(bpu_pkg::CSR_ELEMENT_COUNT, 13'd3);
      add_result(8'hFF, 64'h0000_00FF, 12'd0, 1'b0);
      add_result(8'h00, 64'h0000_0000, 12'd1, 1'b0);
      add_result(8'hA5, 64'h0000_00A5, 12'd2, 1'b1);
      // Width saturates to eight, count zero acts as one
      add_csr(bpu_pkg::CSR_ELEMENT_WIDTH, 13'd15);
      add_csr(bpu_pkg::CSR_ELEMENT_COUNT, 13'd0);
      add_byte(8'h01);
      add_byte(8'h02);
      add_byte(8'h04);
      add_byte(8'h08);
      add_byte(8'h10);
      add_byte(8'h20);
      add_byte(8'h40);
      add_result(8'h80, 64'h8040_2010_0804_0201, 12'd0, 1'b1);
      // Shrink the width mid-block; the stored second plane must be masked
      add_csr(bpu_pkg::CSR_ELEMENT_WIDTH, 13'd4);
      add_csr(bpu_pkg::CSR_ELEMENT_COUNT, 13'd2);
      add_byte(8'h11);
      add_byte(8'h22);
      add_byte(8'h33);
      add_byte(8'h44);
      add_byte(8'h55);
      add_csr(bpu_pkg::CSR_ELEMENT_WIDTH, 13'd2);
      add_result(8'h66, 64'h0000_6622, 12'd1, 1'b1);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            wait_idle();
            write_csr(directed_rows[r].sel, directed_rows[r].value);
         end else begin
            send_byte(directed_rows[r].value[7:0], directed_rows[r].typed,
                      directed_rows[r].want);
         end
      end

      // Width one at the saturated top count; the receiver's long hold lands here
      wait_idle();
      write_csr(bpu_pkg::CSR_ELEMENT_WIDTH, 13'd1);
      write_csr(bpu_pkg::CSR_ELEMENT_COUNT, 13'd8191);
      repeat (HOLD_BYTES) send_byte(8'($urandom_range(0, 255)), 1'b0, none);
      // Close the block on the next byte
      wait_idle();
      write_csr(bpu_pkg::CSR_ELEMENT_COUNT, 13'd1);
      send_byte(8'($urandom_range(0, 255)), 1'b0, none);

      base = bytes_sent;
      trunc = 1'b1;
      while (bytes_sent - base < RANDOM_BYTES) begin
         wait_idle();
         if ($urandom_range(0, 3) == 0)
            write_csr(bpu_pkg::CSR_ELEMENT_WIDTH, 13'($urandom_range(0, 15)));
         else
            write_csr(bpu_pkg::CSR_ELEMENT_WIDTH, 13'($urandom_range(1, 8)));
         if (trunc) begin
            // Start a large block, then cut it short after a few plane-0 bytes
            write_csr(bpu_pkg::CSR_ELEMENT_COUNT,
                      $urandom_range(0, 1) ? 13'd4096 : 13'd8191);
            cut = $urandom_range(1, 16);
            repeat (cut) send_byte(8'($urandom_range(0, 255)), 1'b0, none);
            wait_idle();
            write_csr(bpu_pkg::CSR_ELEMENT_COUNT, 13'($urandom_range(1, cut + 1)));
            do send_byte(8'($urandom_range(0, 255)), 1'b0, none);
            while (!(plane_ctr == 0 && idx_ctr == 0));
         end else begin
            case ($urandom_range(0, 19))
               0:       write_csr(bpu_pkg::CSR_ELEMENT_COUNT, 13'd0);
               1, 2, 3: write_csr(bpu_pkg::CSR_ELEMENT_COUNT, 13'($urandom_range(11, 40)));
               default: write_csr(bpu_pkg::CSR_ELEMENT_COUNT, 13'($urandom_range(1, 10)));
            endcase
            blocks = $urandom_range(1, 3);
            repeat (blocks * eff_planes() * eff_elements())
               send_byte(8'($urandom_range(0, 255)), 1'b0, none);
         end
         trunc = ($urandom_range(0, 7) == 0);
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_elements.size() == 0) begin
         $display("PASS byte_plane_unshuffle_top");
      end else begin
         $display("FAIL byte_plane_unshuffle_top");
      end
      $finish;
   end

endmodule
